// ===== sv/fsc_pkg.sv =====
// Shared types and constants for the frustum sphere cull block.
// Used by fsc_cell, fsc_plane_builder and frustum_sphere_cull_top.
`timescale 1ns / 1ps
package fsc_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int PLANE_COUNT   = 6;
  localparam int CFG_REG_COUNT = 8;
  localparam int CFG_INDEX_W   = 4;
  // plane magnitude after normalizing shift (w may grow to about 2^61)
  localparam int MAG_W         = 62;
  // dividend width: magnitude scaled by the fraction bits plus rounding term
  localparam int NUM_W         = MAG_W + FRACTION_BITS + 1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW0_COLS01 = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW3_COLS23 = 4'd7;

  typedef logic [3:0][3:0][31:0] matrix_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
  } plane_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] idx;
    plane_t     plane;
  } plane_wr_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [30:0]        r;
    logic               pass;
  } cell_data_t;

endpackage

// ===== sv/frustum_sphere_cull_top.sv =====
// Top level of the frustum sphere cull block: configuration registers,
// plane builder and the chain of six culling cells. Depends on fsc_pkg.
`timescale 1ns / 1ps
// A sphere request walks through six cells of two stages each, one plane per
// cell, and then into the output register. The next sphere is accepted only
// once the previous result has moved into the output register, so a new
// sphere is never taken while one is in the chain. After reset or any matrix
// write, the first sphere request waits while the planes are rebuilt by the
// bit-serial square root and divider. Writes to indexes above 7 are ignored.
module frustum_sphere_cull_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fsc_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [63:0]                     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [31:0]              centre_x_i,
  input  logic signed [31:0]              centre_y_i,
  input  logic signed [31:0]              centre_z_i,
  input  logic [30:0]                     radius_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            in_frustum_o
);
  import fsc_pkg::*;

  logic [CFG_REG_COUNT-1:0][63:0] mat_q;
  logic                           stale_q;
  logic                           busy_q;
  logic                           pend_q;
  logic                           pend_res_q;
  logic                           out_valid_q;
  logic                           in_frustum_q;
  logic                           cfg_hit;
  logic                           accept;
  logic                           out_free;
  logic                           build_start;
  logic                           build_done;
  matrix_t                        matrix;
  plane_wr_t                      plane_wr;
  cell_data_t                     cd [PLANE_COUNT+1];

  assign cfg_hit = cfg_we_i && (cfg_index_i >= CFG_ROW0_COLS01)
                            && (cfg_index_i <= CFG_ROW3_COLS23);

  // hold the matrix registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q <= '0;
    end else if (cfg_hit) begin
      mat_q[cfg_index_i[2:0]] <= cfg_data_i;
    end
  end

  // unpack rows into matrix entries
  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      assign matrix[r][c] = mat_q[r*2 + c/2][(c%2)*32 +: 32];
    end
  end

  // mark planes stale on a write, clear when the build finishes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stale_q <= 1'b1;
    end else if (cfg_hit) begin
      stale_q <= 1'b1;
    end else if (build_done) begin
      stale_q <= 1'b0;
    end
  end

  // no restart in the cycle that the finished build clears the stale flag
  assign build_start = stale_q && in_valid_i && !build_done;

  fsc_plane_builder u_builder (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (build_start),
    .matrix_i   (matrix),
    .plane_wr_o (plane_wr),
    .done_o     (build_done)
  );

  assign in_stall_o = stale_q | busy_q;
  assign accept     = in_valid_i & ~in_stall_o;

  // feed the accepted request into the first cell
  always_comb begin
    cd[0].valid = accept;
    cd[0].cx    = centre_x_i;
    cd[0].cy    = centre_y_i;
    cd[0].cz    = centre_z_i;
    cd[0].r     = radius_i;
    cd[0].pass  = 1'b1;
  end

  for (genvar k = 0; k < PLANE_COUNT; k++) begin : g_cell
    fsc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .data_i     (cd[k]),
      .plane_we_i (plane_wr.valid && (plane_wr.idx == 3'(k))),
      .plane_i    (plane_wr.plane),
      .data_o     (cd[k+1])
    );
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // move the chain result to the output register, park it if stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      pend_q       <= 1'b0;
      pend_res_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      in_frustum_q <= 1'b0;
    end else begin
      if (accept) busy_q <= 1'b1;
      if (cd[PLANE_COUNT].valid) begin
        if (out_free) begin
          out_valid_q  <= 1'b1;
          in_frustum_q <= cd[PLANE_COUNT].pass;
          busy_q       <= 1'b0;
        end else begin
          pend_q     <= 1'b1;
          pend_res_q <= cd[PLANE_COUNT].pass;
        end
      end else if (pend_q && out_free) begin
        out_valid_q  <= 1'b1;
        in_frustum_q <= pend_res_q;
        pend_q       <= 1'b0;
        busy_q       <= 1'b0;
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign in_frustum_o = in_frustum_q;

endmodule

// ===== sv/fsc_cell.sv =====
// One culling cell: holds one plane and tests the passing sphere against it.
// Depends on fsc_pkg.
`timescale 1ns / 1ps
module fsc_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fsc_pkg::cell_data_t data_i,
  input  logic                plane_we_i,
  input  fsc_pkg::plane_t     plane_i,
  output fsc_pkg::cell_data_t data_o
);
  import fsc_pkg::*;

  plane_t             plane_q;
  cell_data_t         a_data_q;
  cell_data_t         b_data_q;
  cell_data_t         b_data_d;
  logic signed [63:0] px_q;
  logic signed [63:0] py_q;
  logic signed [63:0] pz_q;
  logic [66:0]        sum_d;

  // hold the plane written by the builder
  always_ff @(posedge clk_i) begin
    if (plane_we_i) begin
      plane_q <= plane_i;
    end
  end

  // stage A: form the three products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_data_q <= '0;
    end else begin
      a_data_q <= data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= plane_q.x * data_i.cx;
    py_q <= plane_q.y * data_i.cy;
    pz_q <= plane_q.z * data_i.cz;
  end

  // stage B: add offset and radius terms, check the sign
  assign sum_d = 67'(px_q) + 67'(py_q) + 67'(pz_q)
               + (67'(plane_q.w) << FRACTION_BITS)
               + (67'({1'b0, a_data_q.r}) << FRACTION_BITS);

  always_comb begin
    b_data_d      = a_data_q;
    b_data_d.pass = a_data_q.pass & ~sum_d[66];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_data_q <= '0;
    end else begin
      b_data_q <= b_data_d;
    end
  end

  assign data_o = b_data_q;

endmodule

// ===== sv/fsc_plane_builder.sv =====
// Plane builder: extracts, normalizes and writes the six frustum planes.
// Bit-serial square root and divider. Depends on fsc_pkg.
`timescale 1ns / 1ps
module fsc_plane_builder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  fsc_pkg::matrix_t   matrix_i,
  output fsc_pkg::plane_wr_t plane_wr_o,
  output logic               done_o
);
  import fsc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_NORM, ST_SQ, ST_SQRT, ST_DIV_CHK, ST_DIV, ST_STORE
  } state_e;

  state_e                  state_q;
  logic [2:0]              plane_q;
  logic [4:0]              cnt_q;
  logic [1:0]              comp_q;
  logic [3:0][MAG_W-1:0]   mag_q;
  logic [3:0]              neg_q;
  logic                    zero_q;
  logic [63:0]             acc_q;
  logic [63:0]             res_q;
  logic [63:0]             bit_q;
  logic [NUM_W-1:0]        rem_q;
  logic [NUM_W-1:0]        div_q;
  logic [29:0]             quo_q;
  logic [3:0][31:0]        comp_val_q;
  plane_wr_t               wr_q;
  logic                    done_q;

  logic [1:0]              row_k;
  logic                    sub_sel;
  logic [3:0][32:0]        raw_mag;
  logic [3:0]              raw_neg;
  logic [MAG_W-1:0]        m_max;
  logic [30:0]             len;
  logic [63:0]             sq_term;
  logic [63:0]             root_try;
  logic [NUM_W-1:0]        num;
  logic [NUM_W-1:0]        lim;
  logic                    div_ge;

  function automatic logic [31:0] apply_sign(input logic neg, input logic [30:0] q);
    logic [31:0] v;
    v = {1'b0, q};
    return neg ? (32'd0 - v) : v;
  endfunction

  // raw plane: row 3 minus or plus row k
  assign sub_sel = (plane_q < 3'd3);
  assign row_k   = sub_sel ? plane_q[1:0] : 2'(plane_q - 3'd3);

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      logic [32:0] a;
      logic [32:0] b;
      logic [32:0] c;
      a = {matrix_i[3][j][31], matrix_i[3][j]};
      b = {matrix_i[row_k][j][31], matrix_i[row_k][j]};
      c = sub_sel ? (a - b) : (a + b);
      raw_neg[j] = c[32];
      raw_mag[j] = c[32] ? (33'd0 - c) : c;
    end
  end

  // largest xyz magnitude
  always_comb begin
    m_max = mag_q[0];
    if (mag_q[1] > m_max) m_max = mag_q[1];
    if (mag_q[2] > m_max) m_max = mag_q[2];
  end

  assign len      = res_q[30:0];
  assign sq_term  = 64'(mag_q[cnt_q[1:0]][29:0] * mag_q[cnt_q[1:0]][29:0]);
  assign root_try = res_q + bit_q;
  assign num      = (NUM_W'(mag_q[comp_q]) << FRACTION_BITS) + NUM_W'(len >> 1);
  assign lim      = NUM_W'(len) << 31;
  assign div_ge   = (rem_q >= div_q);

  // sequence the build, one plane after another
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      plane_q    <= '0;
      cnt_q      <= '0;
      comp_q     <= '0;
      mag_q      <= '0;
      neg_q      <= '0;
      zero_q     <= 1'b0;
      acc_q      <= '0;
      res_q      <= '0;
      bit_q      <= '0;
      rem_q      <= '0;
      div_q      <= '0;
      quo_q      <= '0;
      comp_val_q <= '0;
      wr_q       <= '0;
      done_q     <= 1'b0;
    end else begin
      // pulse the write in the store state, flag done on the last plane
      wr_q.valid <= (state_q == ST_STORE);
      done_q     <= (state_q == ST_STORE) && (plane_q == 3'(PLANE_COUNT - 1));
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            plane_q <= '0;
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          for (int j = 0; j < 4; j++) begin
            mag_q[j] <= MAG_W'(raw_mag[j]);
          end
          neg_q   <= raw_neg;
          zero_q  <= 1'b0;
          state_q <= ST_NORM;
        end
        ST_NORM: begin
          if (m_max == '0) begin
            zero_q  <= 1'b1;
            state_q <= ST_STORE;
          end else if (|m_max[MAG_W-1:30]) begin
            for (int j = 0; j < 4; j++) mag_q[j] <= mag_q[j] >> 1;
          end else if (!m_max[29]) begin
            for (int j = 0; j < 4; j++) mag_q[j] <= mag_q[j] << 1;
          end else begin
            acc_q   <= '0;
            cnt_q   <= '0;
            state_q <= ST_SQ;
          end
        end
        ST_SQ: begin
          acc_q <= acc_q + sq_term;
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd2) begin
            res_q   <= '0;
            bit_q   <= 64'd1 << 62;
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (acc_q >= root_try) begin
            acc_q <= acc_q - root_try;
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q[0]) begin
            comp_q  <= '0;
            state_q <= ST_DIV_CHK;
          end
        end
        ST_DIV_CHK: begin
          if (num >= lim) begin
            comp_val_q[comp_q] <= apply_sign(neg_q[comp_q], 31'h7FFF_FFFF);
            comp_q             <= comp_q + 2'd1;
            if (comp_q == 2'd3) state_q <= ST_STORE;
          end else begin
            rem_q   <= num;
            div_q   <= NUM_W'(len) << 30;
            quo_q   <= '0;
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_ge) rem_q <= rem_q - div_q;
          div_q <= div_q >> 1;
          quo_q <= {quo_q[28:0], div_ge};
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd30) begin
            comp_val_q[comp_q] <= apply_sign(neg_q[comp_q], {quo_q, div_ge});
            comp_q             <= comp_q + 2'd1;
            state_q            <= (comp_q == 2'd3) ? ST_STORE : ST_DIV_CHK;
          end
        end
        ST_STORE: begin
          wr_q.idx   <= plane_q;
          if (zero_q) begin
            wr_q.plane <= '0;
          end else begin
            wr_q.plane.x <= comp_val_q[0];
            wr_q.plane.y <= comp_val_q[1];
            wr_q.plane.z <= comp_val_q[2];
            wr_q.plane.w <= comp_val_q[3];
          end
          if (plane_q == 3'(PLANE_COUNT - 1)) begin
            state_q <= ST_IDLE;
          end else begin
            plane_q <= plane_q + 3'd1;
            state_q <= ST_LOAD;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign plane_wr_o = wr_q;
  assign done_o     = done_q;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for frustum_sphere_cull_top: directed spheres, then
// random sphere streams under several projection matrices. Depends on fsc_pkg.
`timescale 1ns / 1ps
module tb_top;
  import fsc_pkg::*;

  localparam int IDLE_LIMIT  = 20000;
  localparam int DRAIN_WAIT  = 40;
  localparam int PHASE_ITEMS = 240;
  localparam int EXP_NONE    = -1;

  typedef enum int {
    MAT_IDENTITY, MAT_PERSPECTIVE, MAT_RANDOM, MAT_EXTREME, MAT_DEGENERATE, MAT_ZERO
  } mat_kind_e;

  typedef struct {
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic [30:0] r;
    int          verdict;
  } sphere_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [63:0]            cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic signed [31:0]     centre_x_i = '0;
  logic signed [31:0]     centre_y_i = '0;
  logic signed [31:0]     centre_z_i = '0;
  logic [30:0]            radius_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic                   in_frustum_o;

  frustum_sphere_cull_top u_top (.*);

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // local copy of the block state
  logic [63:0]        matrix_regs [CFG_REG_COUNT];
  logic signed [31:0] plane_words [PLANE_COUNT*4];
  bit                 planes_stale = 1'b1;
  bit                 cull_verdicts [$];
  int                 typed_verdict = EXP_NONE;
  int                 errors = 0;
  int                 spheres_sent = 0;
  int                 verdicts_seen = 0;
  int                 passes_seen = 0;
  int                 idle_cycles = 0;
  int                 burst_left = 0;

  function automatic longint mat_word(int row, int col);
    logic [63:0] reg_val;
    logic [31:0] word;
    reg_val = matrix_regs[row*2 + col/2];
    word = (col % 2) ? reg_val[63:32] : reg_val[31:0];
    return longint'(signed'(word));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // rounded n * 2^F / len, clipped to the largest positive word
  function automatic longint unsigned norm_div(longint unsigned n, longint unsigned len);
    longint unsigned q0, rem, q;
    q0 = n / len;
    rem = n % len;
    if (q0 >= (64'd1 << (31 - FRACTION_BITS))) return 64'h7FFF_FFFF;
    q = (q0 << FRACTION_BITS) + ((rem << FRACTION_BITS) + len / 2) / len;
    return (q > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : q;
  endfunction

  // form and normalize the six planes from the matrix copy
  task automatic rebuild_planes();
    longint unsigned mag [4];
    bit              neg [4];
    longint unsigned m, s, len, q;
    longint          c;
    int              k;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      k = p % 3;
      for (int j = 0; j < 4; j++) begin
        c = (p < 3) ? mat_word(3, j) - mat_word(k, j) : mat_word(3, j) + mat_word(k, j);
        neg[j] = c < 0;
        mag[j] = neg[j] ? longint'(-c) : c;
      end
      m = mag[0];
      if (mag[1] > m) m = mag[1];
      if (mag[2] > m) m = mag[2];
      if (m == 0) begin
        for (int j = 0; j < 4; j++) plane_words[p*4 + j] = '0;
        continue;
      end
      while (m >= (64'd1 << 30)) begin
        m >>= 1;
        for (int j = 0; j < 4; j++) mag[j] >>= 1;
      end
      while (m < (64'd1 << 29)) begin
        m <<= 1;
        for (int j = 0; j < 4; j++) mag[j] <<= 1;
      end
      s = mag[0]*mag[0] + mag[1]*mag[1] + mag[2]*mag[2];
      len = int_sqrt(s);
      for (int j = 0; j < 4; j++) begin
        q = norm_div(mag[j], len);
        plane_words[p*4 + j] = neg[j] ? -q[31:0] : q[31:0];
      end
    end
    planes_stale = 1'b0;
  endtask

  // sphere test against all six cached planes
  task automatic predict_in_frustum(input logic signed [31:0] cx, cy, cz,
                                    input logic [30:0] r, output bit pass);
    logic signed [95:0] plane_dist;
    if (planes_stale) rebuild_planes();
    pass = 1'b1;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      plane_dist = 96'(plane_words[p*4]) * 96'(cx) + 96'(plane_words[p*4+1]) * 96'(cy)
                 + 96'(plane_words[p*4+2]) * 96'(cz)
                 + (96'(plane_words[p*4+3]) <<< FRACTION_BITS)
                 + (96'(signed'({1'b0, r})) <<< FRACTION_BITS);
      if (plane_dist < 0) pass = 1'b0;
    end
  endtask

  // track writes and requests, check results
  always @(posedge clk_i) begin
    bit pass, want, progress;
    progress = 1'b0;
    if (rst_ni) begin
      if (cfg_we_i) begin
        progress = 1'b1;
        if (cfg_index_i < CFG_REG_COUNT) begin
          matrix_regs[cfg_index_i[2:0]] = cfg_data_i;
          planes_stale = 1'b1;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        progress = 1'b1;
        predict_in_frustum(centre_x_i, centre_y_i, centre_z_i, radius_i, pass);
        cull_verdicts.push_back((typed_verdict == EXP_NONE) ? pass : typed_verdict[0]);
      end
      if (out_valid_o && !out_stall_i) begin
        progress = 1'b1;
        verdicts_seen++;
        if (in_frustum_o) passes_seen++;
        if (cull_verdicts.size() == 0) begin
          $display("%0t: unexpected result in_frustum=%0b", $time, in_frustum_o);
          errors++;
        end else begin
          want = cull_verdicts.pop_front();
          if (in_frustum_o !== want) begin
            $display("%0t: in_frustum mismatch expected %0b actual %0b",
                     $time, want, in_frustum_o);
            errors++;
          end
        end
      end
      idle_cycles <= progress ? 0 : idle_cycles + 1;
    end
  end

  // receiver stall pattern, rotating through four modes
  int stall_cyc = 0;
  always @(negedge clk_i) begin
    stall_cyc <= stall_cyc + 1;
    case ((stall_cyc / 300) % 4)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ((stall_cyc % 7) < 3);
      default: out_stall_i <= $urandom_range(0, 1);
    endcase
  end

  // timeout on a stuck handshake
  always @(posedge clk_i) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // hold one request until accepted; called at a falling edge
  task automatic send_sphere(input logic [31:0] cx, cy, cz, input logic [30:0] r,
                             input int verdict);
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i = 1'b1;
    centre_x_i = cx;
    centre_y_i = cy;
    centre_z_i = cz;
    radius_i = r;
    typed_verdict = verdict;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    spheres_sent++;
  endtask

  // drain, then write one register
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
    in_valid_i = 1'b0;
    while (cull_verdicts.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [31:0] q16_range(int lo, int hi);
    return 32'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  // load a matrix of the given kind, row by row
  task automatic load_matrix(input mat_kind_e kind);
    logic [31:0] m [4][4];
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) m[r][c] = '0;
    case (kind)
      MAT_IDENTITY: begin
        for (int d = 0; d < 4; d++) m[d][d] = 32'h0001_0000;
      end
      MAT_PERSPECTIVE: begin
        m[0][0] = q16_range(32'h0000_4000, 32'h0003_0000);
        m[1][1] = q16_range(32'h0000_4000, 32'h0003_0000);
        m[2][2] = -q16_range(32'h0001_0000, 32'h0001_8000);
        m[2][3] = -q16_range(32'h0000_0100, 32'h0001_0000);
        m[3][2] = 32'hFFFF_0000;
      end
      MAT_RANDOM: begin
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++) m[r][c] = $urandom();
      end
      MAT_EXTREME: begin
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++)
            m[r][c] = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end
      MAT_DEGENERATE: begin
        // right plane collapses to zero length, the others stay proper
        m[0][0] = 32'h0001_0000;
        m[1][1] = 32'h0001_0000;
        m[2][2] = 32'h0001_0000;
        m[3][0] = 32'h0001_0000;
        m[3][3] = 32'h0002_0000;
      end
      default: ;
    endcase
    for (int r = 0; r < 4; r++) begin
      write_reg(CFG_INDEX_W'(r*2), {m[r][1], m[r][0]});
      write_reg(CFG_INDEX_W'(r*2 + 1), {m[r][3], m[r][2]});
    end
    // unused indexes must change nothing
    write_reg(CFG_INDEX_W'($urandom_range(CFG_REG_COUNT, 15)), {$urandom(), $urandom()});
  endtask

  // random spheres: mostly near the view volume, some with any bit pattern
  task automatic random_spheres(input int count);
    logic [31:0] cx, cy, cz;
    logic [30:0] r;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 80) begin
        cx = q16_range(-32'sh0008_0000, 32'sh0008_0000);
        cy = q16_range(-32'sh0008_0000, 32'sh0008_0000);
        cz = q16_range(-32'sh0014_0000, 32'sh0002_0000);
        r = 31'($urandom_range(0, 32'h0004_0000));
      end else begin
        cx = $urandom();
        cy = $urandom();
        cz = $urandom();
        r = 31'($urandom());
      end
      send_sphere(cx, cy, cz, r, EXP_NONE);
    end
  endtask

  sphere_row_t zero_rows [] = '{
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 31'h0, 1},
    '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h0, 1},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1},
    '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 31'h7FFF_FFFF, 1}
  };
  sphere_row_t unit_rows [] = '{
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 31'h0, 1},
    '{32'h0002_0000, 32'h0000_0000, 32'h0000_0000, 31'h0000_8000, 0},
    '{32'h0002_0000, 32'h0000_0000, 32'h0000_0000, 31'h0001_0000, 1},
    '{32'h0000_0000, 32'hFFFE_0000, 32'h0000_0000, 31'h0001_0000, 1},
    '{32'h0000_0000, 32'h0000_0000, 32'h0003_0000, 31'h0001_0000, 0},
    '{32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 31'h0, 1},
    '{32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 31'h7FFF_FFFF, 1},
    '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, EXP_NONE},
    '{32'h0000_FFFF, 32'h0000_0000, 32'h0000_0000, 31'h0, EXP_NONE},
    '{32'h0001_0001, 32'h0000_0000, 32'h0000_0000, 31'h0, 0}
  };

  mat_kind_e phase_plan [] = '{
    MAT_PERSPECTIVE, MAT_RANDOM, MAT_EXTREME, MAT_DEGENERATE,
    MAT_PERSPECTIVE, MAT_ZERO, MAT_PERSPECTIVE, MAT_RANDOM
  };

  initial begin
    for (int i = 0; i < CFG_REG_COUNT; i++) matrix_regs[i] = '0;
    for (int i = 0; i < PLANE_COUNT*4; i++) plane_words[i] = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // all-zero matrix after reset: every plane is degenerate, everything passes
    foreach (zero_rows[i])
      send_sphere(zero_rows[i].cx, zero_rows[i].cy, zero_rows[i].cz, zero_rows[i].r,
                  zero_rows[i].verdict);
    // identity matrix: unit cube view volume
    load_matrix(MAT_IDENTITY);
    foreach (unit_rows[i])
      send_sphere(unit_rows[i].cx, unit_rows[i].cy, unit_rows[i].cz, unit_rows[i].r,
                  unit_rows[i].verdict);
    random_spheres(20);

    foreach (phase_plan[i]) begin
      load_matrix(phase_plan[i]);
      random_spheres(PHASE_ITEMS);
    end

    in_valid_i = 1'b0;
    while (cull_verdicts.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);

    $display("Sent %0d spheres over %0d matrix settings; %0d results, %0d inside.",
             spheres_sent, phase_plan.size() + 2, verdicts_seen, passes_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
